[design/hrif_pkg.sv]
// ----------------------------------------------------------------------------
// hrif_pkg
// Shared types, constants and helpers for the HID report item framer.
// ----------------------------------------------------------------------------
package hrif_pkg;

   localparam int MAX_DESC_BYTES = 4096;
   localparam int POS_W          = $clog2(MAX_DESC_BYTES);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] LONG_TAG_CODE = 4'hF;
   localparam logic [1:0] SIZE_CODE_4   = 2'h3;

   typedef enum logic [1:0] {
      PH_PREFIX   = 2'd0,
      PH_LONG_LEN = 2'd1,
      PH_LONG_TAG = 2'd2,
      PH_DATA     = 2'd3
   } phase_type;

   typedef struct packed {
      logic        item_is_long;
      logic [1:0]  item_type;
      logic [7:0]  item_tag;
      logic [7:0]  data_bytes;
      logic [31:0] short_value;
      logic [11:0] start_offset;
      logic        truncated;
      logic        final_item;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Low 12 bits of a descriptor position, zero extended when narrower.
   function automatic logic [11:0] to_offset(input logic [POS_W-1:0] pos);
      logic [POS_W+11:0] ext;
      ext = {12'b0, pos};
      return ext[11:0];
   endfunction

endpackage

[design/hrif_front.sv]
// ----------------------------------------------------------------------------
// hrif_front
// Byte framer: tracks the item header and data, pushes one record per item.
// ----------------------------------------------------------------------------
module hrif_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        desc_byte,
   input  logic              end_of_desc,
   output hrif_pkg::push_type push
);

   hrif_pkg::phase_type            phase_ff, phase_in;
   logic [7:0]                     bytes_left_ff, bytes_left_in;
   logic [31:0]                    value_acc_ff, value_acc_in;
   logic [hrif_pkg::POS_W-1:0]     byte_pos_ff, byte_pos_in;
   logic [hrif_pkg::POS_W-1:0]     item_start_ff, item_start_in;
   logic [7:0]                     held_prefix_ff, held_prefix_in;
   logic [7:0]                     held_long_tag_ff, held_long_tag_in;
   logic [7:0]                     held_size_ff, held_size_in;

   logic       done;
   logic       is_long;
   logic [7:0] bl_dec;
   logic [1:0] lane;

   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      value_acc_in     = value_acc_ff;
      byte_pos_in      = byte_pos_ff;
      item_start_in    = item_start_ff;
      held_prefix_in   = held_prefix_ff;
      held_long_tag_in = held_long_tag_ff;
      held_size_in     = held_size_ff;
      done             = 1'b0;
      bl_dec           = bytes_left_ff - 8'd1;
      lane             = held_size_ff[1:0] - bytes_left_ff[1:0];

      unique case (phase_ff)
         hrif_pkg::PH_PREFIX: begin
            item_start_in    = byte_pos_ff;
            held_prefix_in   = desc_byte;
            held_long_tag_in = 8'd0;
            value_acc_in     = 32'd0;
            if (desc_byte[7:4] == hrif_pkg::LONG_TAG_CODE) begin
               held_size_in = 8'd0;
               phase_in     = hrif_pkg::PH_LONG_LEN;
            end else begin
               held_size_in  = (desc_byte[1:0] == hrif_pkg::SIZE_CODE_4) ? 8'd4
                               : {6'd0, desc_byte[1:0]};
               bytes_left_in = held_size_in;
               if (held_size_in == 8'd0) begin
                  done = 1'b1;
               end else begin
                  phase_in = hrif_pkg::PH_DATA;
               end
            end
         end
         hrif_pkg::PH_LONG_LEN: begin
            held_size_in  = desc_byte;
            bytes_left_in = desc_byte;
            phase_in      = hrif_pkg::PH_LONG_TAG;
         end
         hrif_pkg::PH_LONG_TAG: begin
            held_long_tag_in = desc_byte;
            if (bytes_left_ff == 8'd0) begin
               done = 1'b1;
            end else begin
               phase_in = hrif_pkg::PH_DATA;
            end
         end
         hrif_pkg::PH_DATA: begin
            // place the byte in its little-endian lane (short items only)
            if (held_prefix_ff[7:4] != hrif_pkg::LONG_TAG_CODE) begin
               case (lane)
                  2'd0:    value_acc_in[7:0]   = value_acc_ff[7:0]   | desc_byte;
                  2'd1:    value_acc_in[15:8]  = value_acc_ff[15:8]  | desc_byte;
                  2'd2:    value_acc_in[23:16] = value_acc_ff[23:16] | desc_byte;
                  default: value_acc_in[31:24] = value_acc_ff[31:24] | desc_byte;
               endcase
            end
            bytes_left_in = bl_dec;
            if (bl_dec == 8'd0) begin
               done = 1'b1;
            end
         end
         default: ;
      endcase

      is_long = (held_prefix_in[7:4] == hrif_pkg::LONG_TAG_CODE);

      push.valid             = accept && (done || end_of_desc);
      push.item.item_is_long = is_long;
      push.item.item_type    = held_prefix_in[3:2];
      push.item.item_tag     = is_long ? held_long_tag_in : {4'd0, held_prefix_in[7:4]};
      push.item.data_bytes   = held_size_in;
      push.item.short_value  = is_long ? 32'd0 : value_acc_in;
      push.item.start_offset = hrif_pkg::to_offset(item_start_in);
      push.item.truncated    = !done;
      push.item.final_item   = end_of_desc;

      if (done) begin
         phase_in = hrif_pkg::PH_PREFIX;
      end
      byte_pos_in = (byte_pos_ff == hrif_pkg::POS_W'(hrif_pkg::MAX_DESC_BYTES - 1))
                    ? '0 : byte_pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_desc)) begin
         phase_ff         <= hrif_pkg::PH_PREFIX;
         bytes_left_ff    <= 8'd0;
         value_acc_ff     <= 32'd0;
         byte_pos_ff      <= '0;
         item_start_ff    <= '0;
         held_prefix_ff   <= 8'd0;
         held_long_tag_ff <= 8'd0;
         held_size_ff     <= 8'd0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         value_acc_ff     <= value_acc_in;
         byte_pos_ff      <= byte_pos_in;
         item_start_ff    <= item_start_in;
         held_prefix_ff   <= held_prefix_in;
         held_long_tag_ff <= held_long_tag_in;
         held_size_ff     <= held_size_in;
      end
   end

endmodule

[design/hrif_queue.sv]
// ----------------------------------------------------------------------------
// hrif_queue
// Small FIFO of item records between the framer and the output stage.
// ----------------------------------------------------------------------------
module hrif_queue (
   input  logic               clock,
   input  logic               reset,
   input  hrif_pkg::push_type push,
   input  logic               pop,
   output hrif_pkg::head_type head,
   output logic               full
);

   hrif_pkg::item_type                store_ff [hrif_pkg::QUEUE_DEPTH];
   logic [hrif_pkg::QUEUE_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hrif_pkg::QUEUE_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hrif_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                              do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
      head.valid = (count_ff != '0);
      head.item  = store_ff[rd_ptr_ff];
      full       = (count_ff == hrif_pkg::QUEUE_CNT_W'(hrif_pkg::QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/hrif_back.sv]
// ----------------------------------------------------------------------------
// hrif_back
// Output register: takes the queue head and holds it until the beat is taken.
// ----------------------------------------------------------------------------
module hrif_back (
   input  logic               clock,
   input  logic               reset,
   input  hrif_pkg::head_type head,
   output logic               pop,
   input  logic               out_stall,
   output logic               out_valid,
   output hrif_pkg::item_type out_item
);

   logic               valid_ff, valid_in;
   hrif_pkg::item_type item_ff;

   always_comb begin
      pop      = head.valid && (!valid_ff || !out_stall);
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
      out_valid = valid_ff;
      out_item  = item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head.item;
      end
   end

endmodule

[design/hid_report_item_framer.sv]
// ----------------------------------------------------------------------------
// hid_report_item_framer
// Splits a HID report descriptor, one byte per beat, into item records.
// ----------------------------------------------------------------------------
// Feed descriptor bytes on the req_ channel and mark the last one with
// req_end_of_desc; one rsp_ beat comes out for every completed item, plus a
// beat flagged truncated when the descriptor ends inside an item. The block
// takes one byte per clock cycle, sustained: the framer updates its state
// once per byte, and finished items wait in a four-entry queue in front of
// the output register, so req_stall rises only when that queue is full. A
// record is queued as its closing byte is accepted, then moves to the output
// register. After the final byte the framer returns to its reset state, so
// the next descriptor counts offsets from zero again. Long item payload
// bytes are counted but not passed out; short_value is zero for long items.
// ----------------------------------------------------------------------------
module hid_report_item_framer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_desc_byte,
   input  logic        req_end_of_desc,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_is_long,
   output logic [1:0]  rsp_item_type,
   output logic [7:0]  rsp_item_tag,
   output logic [7:0]  rsp_data_bytes,
   output logic [31:0] rsp_short_value,
   output logic [11:0] rsp_start_offset,
   output logic        rsp_truncated,
   output logic        rsp_final_item
);

   hrif_pkg::push_type push;
   hrif_pkg::head_type head;
   hrif_pkg::item_type out_item;
   logic               queue_full;
   logic               pop;
   logic               accept;

   // Hold off new bytes while the queue cannot take another record.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   hrif_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .desc_byte   (req_desc_byte),
      .end_of_desc (req_end_of_desc),
      .push        (push)
   );

   hrif_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   hrif_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_item  (out_item)
   );

   // Break the record out onto the result ports.
   assign rsp_item_is_long = out_item.item_is_long;
   assign rsp_item_type    = out_item.item_type;
   assign rsp_item_tag     = out_item.item_tag;
   assign rsp_data_bytes   = out_item.data_bytes;
   assign rsp_short_value  = out_item.short_value;
   assign rsp_start_offset = out_item.start_offset;
   assign rsp_truncated    = out_item.truncated;
   assign rsp_final_item   = out_item.final_item;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream check of the HID report item framer against a local predictor.
// ----------------------------------------------------------------------------
// A short table of hand-picked descriptor bytes goes first. It covers
// zero-size items, four-byte items, long items, the reserved type and several
// ways a descriptor can end inside an item. Random descriptors follow. Most
// are built from whole items with random content. The rest are raw noise,
// cut short or padded with extra bytes. Each byte the block accepts is fed
// to the predictor kept here, and any item that byte closes is queued. Every
// rsp_ beat is compared field by field with the oldest queued item. Both
// sides idle at random, except in one calm stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BYTES = 1300;
   localparam int MAX_PRINTED = 40;

   // one descriptor byte; typed rows carry their own expected item
   typedef struct packed {
      logic [7:0]         data;
      logic               eod;
      logic               typed;
      hrif_pkg::item_type want;
   } desc_beat_type;

   // Directed part. An expected item is typed in only where it can be read
   // straight off the bytes; the other rows lean on the predictor.
   localparam desc_beat_type DIRECTED_ROWS [25] = '{
      // zero-size short item, reserved type
      '{8'h0C, 1'b0, 1'b1, '{1'b0, 2'd3, 8'h00, 8'd0, 32'h0, 12'd0, 1'b0, 1'b0}},
      // four-byte global item, all ones
      '{8'hE7, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{1'b0, 2'd1, 8'h0E, 8'd4, 32'hFFFF_FFFF, 12'd1, 1'b0, 1'b0}},
      // zero-length long item closes on its tag byte
      '{8'hFE, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, '{1'b1, 2'd3, 8'hFF, 8'd0, 32'h0, 12'd6, 1'b0, 1'b0}},
      // long item with a two-byte payload
      '{8'hF1, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, '0},
      '{8'hBB, 1'b0, 1'b0, '0},
      // two-byte local item that is also the last item of the descriptor
      '{8'h0A, 1'b0, 1'b0, '0},
      '{8'h34, 1'b0, 1'b0, '0},
      '{8'h12, 1'b1, 1'b0, '0},
      // descriptor ends right after a short prefix
      '{8'h81, 1'b1, 1'b1, '{1'b0, 2'd0, 8'h08, 8'd1, 32'h0, 12'd0, 1'b1, 1'b1}},
      // descriptor ends right after a long prefix
      '{8'hF3, 1'b1, 1'b1, '{1'b1, 2'd0, 8'h00, 8'd0, 32'h0, 12'd0, 1'b1, 1'b1}},
      // descriptor ends on the long length byte
      '{8'hF4, 1'b0, 1'b0, '0},
      '{8'h07, 1'b1, 1'b1, '{1'b1, 2'd1, 8'h00, 8'd7, 32'h0, 12'd0, 1'b1, 1'b1}},
      // descriptor ends inside a long payload
      '{8'hF8, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h42, 1'b0, 1'b0, '0},
      '{8'h99, 1'b1, 1'b0, '0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_desc_byte = 8'h00;
   logic        req_end_of_desc = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_is_long;
   logic [1:0]  rsp_item_type;
   logic [7:0]  rsp_item_tag;
   logic [7:0]  rsp_data_bytes;
   logic [31:0] rsp_short_value;
   logic [11:0] rsp_start_offset;
   logic        rsp_truncated;
   logic        rsp_final_item;

   desc_beat_type      desc_feed [$];
   desc_beat_type      cur_beat = '0;
   hrif_pkg::item_type items_due [$];
   int                 beats_taken = 0;
   int                 mismatch_count = 0;
   int                 cycle_count = 0;

   // predictor state
   hrif_pkg::phase_type fr_phase;
   logic [7:0]          fr_left;
   logic [31:0]         fr_acc;
   logic [11:0]         fr_pos;
   logic [11:0]         fr_start;
   logic [7:0]          fr_prefix;
   logic [7:0]          fr_ltag;
   logic [7:0]          fr_size;

   // no idling on either side for a stretch of beats
   wire calm = (beats_taken >= 300) && (beats_taken < 700);

   hid_report_item_framer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_desc_byte    (req_desc_byte),
      .req_end_of_desc  (req_end_of_desc),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_is_long (rsp_item_is_long),
      .rsp_item_type    (rsp_item_type),
      .rsp_item_tag     (rsp_item_tag),
      .rsp_data_bytes   (rsp_data_bytes),
      .rsp_short_value  (rsp_short_value),
      .rsp_start_offset (rsp_start_offset),
      .rsp_truncated    (rsp_truncated),
      .rsp_final_item   (rsp_final_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic clear_framer();
      fr_phase  = hrif_pkg::PH_PREFIX;
      fr_left   = 8'h00;
      fr_acc    = 32'h0;
      fr_pos    = 12'h000;
      fr_start  = 12'h000;
      fr_prefix = 8'h00;
      fr_ltag   = 8'h00;
      fr_size   = 8'h00;
   endtask

   // Advance the predictor by one byte; report the item it closes, or
   // the truncated item when the descriptor ends mid-item.
   task automatic frame_byte(input logic [7:0] b, input logic eod,
                             output bit made, output hrif_pkg::item_type rec);
      logic       done;
      logic       lng;
      logic [1:0] idx;
      done = 1'b0;
      made = 1'b0;
      rec  = '0;
      case (fr_phase)
         hrif_pkg::PH_PREFIX: begin
            fr_start  = fr_pos;
            fr_prefix = b;
            fr_ltag   = 8'h00;
            fr_acc    = 32'h0;
            if (b[7:4] == hrif_pkg::LONG_TAG_CODE) begin
               fr_size  = 8'h00;
               fr_phase = hrif_pkg::PH_LONG_LEN;
            end else begin
               fr_size = (b[1:0] == hrif_pkg::SIZE_CODE_4) ? 8'd4 : {6'd0, b[1:0]};
               fr_left = fr_size;
               if (fr_left == 8'h00) done = 1'b1;
               else fr_phase = hrif_pkg::PH_DATA;
            end
         end
         hrif_pkg::PH_LONG_LEN: begin
            fr_size  = b;
            fr_left  = b;
            fr_phase = hrif_pkg::PH_LONG_TAG;
         end
         hrif_pkg::PH_LONG_TAG: begin
            fr_ltag = b;
            if (fr_left == 8'h00) done = 1'b1;
            else fr_phase = hrif_pkg::PH_DATA;
         end
         default: begin
            // pack short data little-endian; long payload is only counted
            if (fr_prefix[7:4] != hrif_pkg::LONG_TAG_CODE) begin
               idx    = fr_size[1:0] - fr_left[1:0];
               fr_acc = fr_acc | ({24'd0, b} << (8 * idx));
            end
            fr_left = fr_left - 8'd1;
            if (fr_left == 8'h00) done = 1'b1;
         end
      endcase
      lng = (fr_prefix[7:4] == hrif_pkg::LONG_TAG_CODE);
      if (done || eod) begin
         made = 1'b1;
         rec.item_is_long = lng;
         rec.item_type    = fr_prefix[3:2];
         rec.item_tag     = lng ? fr_ltag : {4'h0, fr_prefix[7:4]};
         rec.data_bytes   = fr_size;
         rec.short_value  = lng ? 32'h0 : fr_acc;
         rec.start_offset = fr_start;
         rec.truncated    = !done;
         rec.final_item   = eod;
         if (done) fr_phase = hrif_pkg::PH_PREFIX;
      end
      if (eod) clear_framer();
      else fr_pos = fr_pos + 12'd1;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic eod);
      desc_beat_type nb;
      nb        = '0;
      nb.data   = data;
      nb.eod    = eod;
      desc_feed = {desc_feed, nb};
   endtask

   // Queue one random descriptor: mostly whole items with random content,
   // sometimes raw noise, cut short or padded. With min_bytes set, keep
   // adding items (long payloads up to 255 bytes) until it is that long.
   task automatic queue_descriptor(input int n_items, input int min_bytes);
      int         first;
      int         i;
      int         len;
      logic [7:0] pre;
      first = desc_feed.size();
      if (min_bytes == 0 && $urandom_range(9) == 0) begin
         len = $urandom_range(16, 1);
         repeat (len) push_byte(8'($urandom), $urandom_range(19) == 0);
         desc_feed[desc_feed.size() - 1].eod = 1'b1;
         return;
      end
      i = 0;
      while (i < n_items || desc_feed.size() - first < min_bytes) begin
         if ($urandom_range(3) == 0) begin
            push_byte({hrif_pkg::LONG_TAG_CODE, 4'($urandom)}, 1'b0);
            if (min_bytes > 0 || $urandom_range(39) == 0) len = $urandom_range(255);
            else len = $urandom_range(5);
            push_byte(len[7:0], 1'b0);
            push_byte(8'($urandom), 1'b0);
         end else begin
            pre = 8'($urandom);
            if (pre[7:4] == hrif_pkg::LONG_TAG_CODE) pre[7:4] = 4'($urandom_range(14));
            push_byte(pre, 1'b0);
            len = (pre[1:0] == hrif_pkg::SIZE_CODE_4) ? 4 : int'(pre[1:0]);
         end
         repeat (len) push_byte(8'($urandom), 1'b0);
         i++;
      end
      case ($urandom_range(9))
         0, 1: begin
            // drop a few trailing bytes so the end often lands mid-item
            repeat ($urandom_range(3, 1))
               if (desc_feed.size() > first + 1) void'(desc_feed.pop_back());
         end
         2: repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0);
         default: ;
      endcase
      desc_feed[desc_feed.size() - 1].eod = 1'b1;
   endtask

   // Request side: predict on every accepted beat, then hold or advance.
   always @(posedge clock) begin
      hrif_pkg::item_type predicted;
      bit                 produced;
      if (reset) begin
         req_valid <= 1'b0;
         clear_framer();
      end else begin
         if (req_valid && !req_stall) begin
            frame_byte(cur_beat.data, cur_beat.eod, produced, predicted);
            if (produced)
               items_due = {items_due, (cur_beat.typed ? cur_beat.want : predicted)};
            beats_taken <= beats_taken + 1;
         end
         // hold a stalled beat as it is; otherwise advance or idle
         if (!req_valid || !req_stall) begin
            if (desc_feed.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
               cur_beat = desc_feed.pop_front();
               req_valid       <= 1'b1;
               req_desc_byte   <= cur_beat.data;
               req_end_of_desc <= cur_beat.eod;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: stall at random outside the calm stretch.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 14);
   end

   // Compare each accepted result beat with the oldest queued item.
   always @(posedge clock) begin
      hrif_pkg::item_type seen;
      hrif_pkg::item_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_item_is_long, rsp_item_type, rsp_item_tag, rsp_data_bytes,
                 rsp_short_value, rsp_start_offset, rsp_truncated, rsp_final_item};
         if (items_due.size() == 0) begin
            flag_mismatch("unexpected item, start_offset", 32'(seen.start_offset), 32'h0);
         end else begin
            due = items_due.pop_front();
            if (seen.item_is_long != due.item_is_long)
               flag_mismatch("item_is_long", 32'(seen.item_is_long), 32'(due.item_is_long));
            if (seen.item_type != due.item_type)
               flag_mismatch("item_type", 32'(seen.item_type), 32'(due.item_type));
            if (seen.item_tag != due.item_tag)
               flag_mismatch("item_tag", 32'(seen.item_tag), 32'(due.item_tag));
            if (seen.data_bytes != due.data_bytes)
               flag_mismatch("data_bytes", 32'(seen.data_bytes), 32'(due.data_bytes));
            if (seen.short_value != due.short_value)
               flag_mismatch("short_value", seen.short_value, due.short_value);
            if (seen.start_offset != due.start_offset)
               flag_mismatch("start_offset", 32'(seen.start_offset),
                             32'(due.start_offset));
            if (seen.truncated != due.truncated)
               flag_mismatch("truncated", 32'(seen.truncated), 32'(due.truncated));
            if (seen.final_item != due.final_item)
               flag_mismatch("final_item", 32'(seen.final_item), 32'(due.final_item));
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int i;
      int stop_at;
      // directed rows first, then random descriptors
      for (i = 0; i < 25; i++) desc_feed = {desc_feed, DIRECTED_ROWS[i]};
      stop_at = desc_feed.size() + RANDOM_BYTES;
      while (desc_feed.size() < stop_at) queue_descriptor($urandom_range(12, 1), 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain: every byte taken and every queued item seen
      while (desc_feed.size() > 0 || req_valid || items_due.size() > 0)
         @(posedge clock);
      // give any stray result time to show up
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && items_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
design/hrif_pkg.sv
design/hrif_front.sv
design/hrif_queue.sv
design/hrif_back.sv
design/hid_report_item_framer.sv
sim/tb.sv
